### rtl/ifde_pkg.sv
`default_nettype none

package ifde_pkg;

    // frame and palette geometry
    localparam int FRAME_WIDTH     = 320;
    localparam int FRAME_HEIGHT    = 200;
    localparam int PAL_ENTRY_COUNT = 256;
    localparam int STORE_DEPTH     = 256;

    // position counters also hold the frame size itself
    localparam int COL_W  = $clog2(FRAME_WIDTH + 1);
    localparam int ROW_W  = $clog2(FRAME_HEIGHT + 1);
    // width for region bound compares
    localparam int WIDE_W = 14;

    localparam int CFG_DATA_W  = 9;
    localparam int CFG_INDEX_W = 3;

    // configuration register indexes
    typedef enum logic [CFG_INDEX_W-1:0] {
        CFG_REGION_X       = 3'd0,
        CFG_REGION_Y       = 3'd1,
        CFG_REGION_WIDTH   = 3'd2,
        CFG_REGION_HEIGHT  = 3'd3,
        CFG_PALETTE_CMP_ON = 3'd4
    } cfg_index_t;

    // operation codes
    localparam logic OP_LOAD_PALETTE = 1'b0;
    localparam logic OP_PIXEL        = 1'b1;

    typedef struct packed {
        logic        operation;
        logic [7:0]  entry_index;
        logic [23:0] ref_color;
        logic [23:0] cand_color;
        logic [7:0]  ref_index;
        logic [7:0]  cand_index;
        logic        frame_end;
    } item_t;

    typedef struct packed {
        logic [15:0] index_mismatches;
        logic [15:0] color_mismatches;
        logic [8:0]  box_x;
        logic [7:0]  box_y;
        logic [8:0]  box_width;
        logic [7:0]  box_height;
        logic [8:0]  entry_mismatches;
        logic [9:0]  channel_diff_count;
        logic        region_error;
    } result_t;

    // controller to datapath
    typedef struct packed {
        logic load_entry;
        logic take_pixel;
        logic update;
        logic finish;
    } cmd_t;

    // datapath to controller
    typedef struct packed {
        logic last_pixel;
    } status_t;

endpackage

`default_nettype wire

### rtl/ifde_item_if.sv
`default_nettype none

interface ifde_item_if;
    logic            valid;
    logic            ready;
    ifde_pkg::item_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

### rtl/ifde_result_if.sv
`default_nettype none

interface ifde_result_if;
    logic              valid;
    logic              ready;
    ifde_pkg::result_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

### rtl/ifde_ctrl.sv
`default_nettype none

module ifde_ctrl (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              item_valid,
    input  wire logic              item_operation,
    output logic                   item_ready,
    output logic                   result_valid,
    input  wire logic              result_ready,
    input  wire ifde_pkg::status_t status,
    output ifde_pkg::cmd_t         cmd
);

    typedef enum logic [2:0] {
        S_IDLE   = 3'b001,
        S_UPDATE = 3'b010,
        S_FINISH = 3'b100
    } state_t;

    state_t state_reg, state_next;
    logic   out_valid_reg, out_valid_next;
    logic   accept;
    logic   slot_free;

    assign item_ready   = (state_reg == S_IDLE);
    assign accept       = item_valid && item_ready;
    assign slot_free    = !out_valid_reg || result_ready;
    assign result_valid = out_valid_reg;

    // sequencing of one transaction
    always_comb
    begin
        state_next     = state_reg;
        out_valid_next = out_valid_reg;
        cmd            = '0;
        if (out_valid_reg && result_ready)
        begin
            out_valid_next = 1'b0;
        end
        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    if (item_operation == ifde_pkg::OP_PIXEL)
                    begin
                        cmd.take_pixel = 1'b1;
                        state_next     = S_UPDATE;
                    end
                    else
                    begin
                        cmd.load_entry = 1'b1;
                    end
                end
            end
            S_UPDATE:
            begin
                cmd.update = 1'b1;
                state_next = status.last_pixel ? S_FINISH : S_IDLE;
            end
            S_FINISH:
            begin
                // wait for the output register to free up
                if (slot_free)
                begin
                    cmd.finish     = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

`default_nettype wire

### rtl/ifde_datapath.sv
`default_nettype none

module ifde_datapath (
    input  wire logic                                 clk,
    input  wire logic                                 rst_n,
    input  wire logic                                 cfg_we,
    input  wire logic [ifde_pkg::CFG_INDEX_W-1:0]     cfg_index,
    input  wire logic [ifde_pkg::CFG_DATA_W-1:0]      cfg_data,
    input  wire ifde_pkg::item_t                      item,
    input  wire ifde_pkg::cmd_t                       cmd,
    output ifde_pkg::status_t                         status,
    output ifde_pkg::result_t                         result
);

    localparam int COL_W  = ifde_pkg::COL_W;
    localparam int ROW_W  = ifde_pkg::ROW_W;
    localparam int WIDE_W = ifde_pkg::WIDE_W;

    // configuration registers
    logic [8:0] region_x_reg;
    logic [7:0] region_y_reg;
    logic [8:0] region_width_reg;
    logic [7:0] region_height_reg;
    logic       palette_cmp_on_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            region_x_reg       <= 9'd0;
            region_y_reg       <= 8'd0;
            region_width_reg   <= 9'd320;
            region_height_reg  <= 8'd200;
            palette_cmp_on_reg <= 1'b1;
        end
        else if (cfg_we)
        begin
            case (ifde_pkg::cfg_index_t'(cfg_index))
                ifde_pkg::CFG_REGION_X:       region_x_reg       <= cfg_data[8:0];
                ifde_pkg::CFG_REGION_Y:       region_y_reg       <= cfg_data[7:0];
                ifde_pkg::CFG_REGION_WIDTH:   region_width_reg   <= cfg_data[8:0];
                ifde_pkg::CFG_REGION_HEIGHT:  region_height_reg  <= cfg_data[7:0];
                ifde_pkg::CFG_PALETTE_CMP_ON: palette_cmp_on_reg <= cfg_data[0];
                default:
                begin
                end
            endcase
        end
    end

    // region check against frame bounds
    logic [WIDE_W-1:0] rx_w, ry_w, rw_w, rh_w;
    logic              region_bad;

    assign rx_w = WIDE_W'(region_x_reg);
    assign ry_w = WIDE_W'(region_y_reg);
    assign rw_w = WIDE_W'(region_width_reg);
    assign rh_w = WIDE_W'(region_height_reg);

    assign region_bad = (rw_w == '0) || (rh_w == '0)
                     || (rx_w >= WIDE_W'(ifde_pkg::FRAME_WIDTH))
                     || (ry_w >= WIDE_W'(ifde_pkg::FRAME_HEIGHT))
                     || (rx_w + rw_w > WIDE_W'(ifde_pkg::FRAME_WIDTH))
                     || (ry_w + rh_w > WIDE_W'(ifde_pkg::FRAME_HEIGHT));

    // palette stores
    logic [23:0] ref_mem  [ifde_pkg::STORE_DEPTH];
    logic [23:0] cand_mem [ifde_pkg::STORE_DEPTH];
    logic [23:0] ref_rd_reg, cand_rd_reg;
    logic        entry_ok;

    assign entry_ok = (9'(item.entry_index) < 9'(ifde_pkg::PAL_ENTRY_COUNT));

    always_ff @(posedge clk)
    begin
        if (cmd.load_entry && entry_ok)
        begin
            ref_mem[item.entry_index]  <= item.ref_color;
            cand_mem[item.entry_index] <= item.cand_color;
        end
        if (cmd.take_pixel)
        begin
            ref_rd_reg  <= ref_mem[item.ref_index];
            cand_rd_reg <= cand_mem[item.cand_index];
        end
    end

    // palette load channel compare
    logic [1:0]  chan_diff;
    logic [10:0] chan_sum;

    assign chan_diff = 2'(item.ref_color[23:16] != item.cand_color[23:16])
                     + 2'(item.ref_color[15:8]  != item.cand_color[15:8])
                     + 2'(item.ref_color[7:0]   != item.cand_color[7:0]);

    // position and pixel capture
    logic [COL_W-1:0]  col_reg;
    logic [ROW_W-1:0]  row_reg;
    logic [COL_W-1:0]  pix_col_reg;
    logic [ROW_W-1:0]  pix_row_reg;
    logic              hit_reg, idx_diff_reg, last_reg, ref_ok_reg, cand_ok_reg;
    logic [WIDE_W-1:0] x_w, y_w;
    logic              in_region;

    assign x_w       = WIDE_W'(col_reg);
    assign y_w       = WIDE_W'(row_reg);
    assign in_region = (x_w >= rx_w) && (x_w - rx_w < rw_w)
                    && (y_w >= ry_w) && (y_w - ry_w < rh_w);

    always_ff @(posedge clk)
    begin
        if (cmd.take_pixel)
        begin
            pix_col_reg  <= col_reg;
            pix_row_reg  <= row_reg;
            hit_reg      <= !region_bad && in_region;
            idx_diff_reg <= (item.ref_index != item.cand_index);
            ref_ok_reg   <= (9'(item.ref_index) < 9'(ifde_pkg::PAL_ENTRY_COUNT));
            cand_ok_reg  <= (9'(item.cand_index) < 9'(ifde_pkg::PAL_ENTRY_COUNT));
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            last_reg <= 1'b0;
        end
        else if (cmd.take_pixel)
        begin
            last_reg <= item.frame_end;
        end
    end

    assign status.last_pixel = last_reg;

    // rendered colors
    logic [23:0] ref_color_px, cand_color_px;
    logic        color_diff;

    assign ref_color_px  = ref_ok_reg  ? ref_rd_reg  : 24'd0;
    assign cand_color_px = cand_ok_reg ? cand_rd_reg : 24'd0;
    assign color_diff    = (ref_color_px != cand_color_px);

    // accumulators
    logic [COL_W-1:0] min_col_reg, max_col_reg;
    logic [ROW_W-1:0] min_row_reg, max_row_reg;
    logic [15:0]      index_count_reg, color_count_reg;
    logic [8:0]       entry_count_reg;
    logic [9:0]       channel_count_reg;
    logic [COL_W-1:0] col_inc;
    logic [ROW_W-1:0] row_inc;

    assign chan_sum = 11'(channel_count_reg) + 11'(chan_diff);
    assign col_inc  = col_reg + COL_W'(1);
    assign row_inc  = row_reg + ROW_W'(1);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg           <= '0;
            row_reg           <= '0;
            min_col_reg       <= COL_W'(ifde_pkg::FRAME_WIDTH);
            min_row_reg       <= ROW_W'(ifde_pkg::FRAME_HEIGHT);
            max_col_reg       <= '0;
            max_row_reg       <= '0;
            index_count_reg   <= '0;
            color_count_reg   <= '0;
            entry_count_reg   <= '0;
            channel_count_reg <= '0;
        end
        else if (cmd.finish)
        begin
            col_reg           <= '0;
            row_reg           <= '0;
            min_col_reg       <= COL_W'(ifde_pkg::FRAME_WIDTH);
            min_row_reg       <= ROW_W'(ifde_pkg::FRAME_HEIGHT);
            max_col_reg       <= '0;
            max_row_reg       <= '0;
            index_count_reg   <= '0;
            color_count_reg   <= '0;
            entry_count_reg   <= '0;
            channel_count_reg <= '0;
        end
        else
        begin
            // palette mismatch counts, saturating
            if (cmd.load_entry && entry_ok && palette_cmp_on_reg)
            begin
                if (chan_diff != 2'd0 && entry_count_reg != 9'h1FF)
                begin
                    entry_count_reg <= entry_count_reg + 9'd1;
                end
                channel_count_reg <= (chan_sum > 11'h3FF) ? 10'h3FF : chan_sum[9:0];
            end
            // raster position advance with wrap
            if (cmd.take_pixel)
            begin
                if (32'(col_inc) >= ifde_pkg::FRAME_WIDTH)
                begin
                    col_reg <= '0;
                    row_reg <= (32'(row_inc) >= ifde_pkg::FRAME_HEIGHT) ? '0 : row_inc;
                end
                else
                begin
                    col_reg <= col_inc;
                end
            end
            // region pixel compare
            if (cmd.update && hit_reg)
            begin
                if (idx_diff_reg)
                begin
                    if (index_count_reg != 16'hFFFF)
                    begin
                        index_count_reg <= index_count_reg + 16'd1;
                    end
                    if (pix_col_reg < min_col_reg) min_col_reg <= pix_col_reg;
                    if (pix_row_reg < min_row_reg) min_row_reg <= pix_row_reg;
                    if (pix_col_reg > max_col_reg) max_col_reg <= pix_col_reg;
                    if (pix_row_reg > max_row_reg) max_row_reg <= pix_row_reg;
                end
                if (color_diff && color_count_reg != 16'hFFFF)
                begin
                    color_count_reg <= color_count_reg + 16'd1;
                end
            end
        end
    end

    // result register
    ifde_pkg::result_t result_reg, result_next;
    logic [COL_W-1:0]  box_w;
    logic [ROW_W-1:0]  box_h;

    assign box_w = max_col_reg - min_col_reg + COL_W'(1);
    assign box_h = max_row_reg - min_row_reg + ROW_W'(1);

    always_comb
    begin
        result_next = '0;
        if (region_bad)
        begin
            result_next.region_error = 1'b1;
        end
        else
        begin
            result_next.index_mismatches   = index_count_reg;
            result_next.color_mismatches   = color_count_reg;
            result_next.entry_mismatches   = entry_count_reg;
            result_next.channel_diff_count = channel_count_reg;
            if (index_count_reg != 16'd0)
            begin
                result_next.box_x      = 9'(min_col_reg);
                result_next.box_y      = 8'(min_row_reg);
                result_next.box_width  = 9'(box_w);
                result_next.box_height = 8'(box_h);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.finish)
        begin
            result_reg <= result_next;
        end
    end

    assign result = result_reg;

endmodule

`default_nettype wire

### rtl/indexed_frame_diff_engine.sv
// Indexed frame difference engine.
// Input channel "item" (valid/ready) carries either a palette entry pair
// (operation 0) or a pixel index pair in raster order (operation 1).
// Output channel "result" (valid/ready) carries one summary per pixel that
// has frame_end set: index and color mismatch counts, mismatch bounding
// box, palette entry/channel mismatch counts and the region error flag.
// Region and palette compare settings are written through cfg_we,
// cfg_index and cfg_data; the user must do so only while no frame is in
// flight, as the block itself does not enforce this.
// A palette load is taken in the idle state. A pixel is accepted there with
// its palette reads registered, then updates the counters in the update step;
// the last pixel of a frame then loads the result register in a finish step.
// The result sits in an output register, so new transactions are accepted
// while it waits. If the receiver is still stalled when the next frame ends,
// the block holds in its final step and takes no input until the old
// result has been taken.
// Reset clears counters, accumulators and returns the settings to a full
// 320x200 region with palette compare on; palette contents are undefined
// until loaded.
`default_nettype none

module indexed_frame_diff_engine (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              cfg_we,
    input  wire logic [ifde_pkg::CFG_INDEX_W-1:0]  cfg_index,
    input  wire logic [ifde_pkg::CFG_DATA_W-1:0]   cfg_data,
    ifde_item_if.sink                              item,
    ifde_result_if.source                          result
);

    ifde_pkg::cmd_t    cmd;
    ifde_pkg::status_t status;
    logic              item_ready;
    logic              result_valid;

    // control sequencer
    ifde_ctrl u_ctrl (
        .clk            (clk),
        .rst_n          (rst_n),
        .item_valid     (item.valid),
        .item_operation (item.data.operation),
        .item_ready     (item_ready),
        .result_valid   (result_valid),
        .result_ready   (result.ready),
        .status         (status),
        .cmd            (cmd)
    );

    // palette stores, counters and result register
    ifde_datapath u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .item      (item.data),
        .cmd       (cmd),
        .status    (status),
        .result    (result.data)
    );

    assign item.ready   = item_ready;
    assign result.valid = result_valid;

endmodule

`default_nettype wire
